// ----- rtl/btpgi_pkg.sv -----
// ----------------------------------------------------------------------------
// btpgi_pkg
// Types, widths and codes shared by the Bezier triangle point index block.
// ----------------------------------------------------------------------------
`default_nettype none

package btpgi_pkg;

	// Highest Bezier degree the block accepts
	localparam int unsigned MAX_DEGREE = 15;

	// Field widths
	localparam int unsigned DEG_W      = 4;
	localparam int unsigned CORNER_W   = 24;
	localparam int unsigned SIDE_W     = 25;
	localparam int unsigned TRI_W      = 24;
	localparam int unsigned BEZ_W      = 4;
	localparam int unsigned POINT_W    = 32;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 25;

	// Kind of control point
	typedef enum logic [KIND_W-1:0] {
		KIND_VERTEX   = 2'd0,
		KIND_EDGE     = 2'd1,
		KIND_INTERIOR = 2'd2
	} kind_t;

	// Result status
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEGREE       = 2'd0,
		REG_NUM_VERTICES = 2'd1,
		REG_NUM_EDGES    = 2'd2
	} cfg_reg_t;

	// Interior points per triangle: (d-1)(d-2)/2, meaningful for d >= 2
	function automatic logic [6:0] tri_points(input logic [DEG_W-1:0] d);
		logic [7:0] prod;
		prod = 8'((8'(d) - 8'd1) * (8'(d) - 8'd2));
		return 7'(prod >> 1);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/btpgi_ifs.sv -----
// ----------------------------------------------------------------------------
// btpgi channel interfaces
// Request, result and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

// Index request: triangle topology plus Bezier index
interface btpgi_req_if;
	logic                              valid;
	logic                              ready;
	logic [btpgi_pkg::CORNER_W-1:0]    corner_a;
	logic [btpgi_pkg::CORNER_W-1:0]    corner_b;
	logic [btpgi_pkg::CORNER_W-1:0]    corner_c;
	logic [btpgi_pkg::SIDE_W-1:0]      side_a;
	logic [btpgi_pkg::SIDE_W-1:0]      side_b;
	logic [btpgi_pkg::SIDE_W-1:0]      side_c;
	logic [2:0]                        side_forward;
	logic [btpgi_pkg::TRI_W-1:0]       tri_number;
	logic [btpgi_pkg::BEZ_W-1:0]       bez_i;
	logic [btpgi_pkg::BEZ_W-1:0]       bez_j;
	logic [btpgi_pkg::BEZ_W-1:0]       bez_k;

	modport source (
		output valid, corner_a, corner_b, corner_c, side_a, side_b, side_c,
		       side_forward, tri_number, bez_i, bez_j, bez_k,
		input  ready
	);
	modport sink (
		input  valid, corner_a, corner_b, corner_c, side_a, side_b, side_c,
		       side_forward, tri_number, bez_i, bez_j, bez_k,
		output ready
	);
endinterface

// Result: global control point index
interface btpgi_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [btpgi_pkg::POINT_W-1:0]     global_point;
	logic [btpgi_pkg::KIND_W-1:0]      point_kind;
	logic [btpgi_pkg::STATUS_W-1:0]    status;

	modport source (output valid, global_point, point_kind, status, input ready);
	modport sink   (input valid, global_point, point_kind, status, output ready);
endinterface

// Configuration register write
interface btpgi_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [btpgi_pkg::CFG_IDX_W-1:0]   index;
	logic [btpgi_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bezier_triangle_point_global_index.sv -----
// ----------------------------------------------------------------------------
// bezier_triangle_point_global_index
// Maps a Bezier index within a mesh triangle to a global control point index.
// ----------------------------------------------------------------------------
// Four-stage pipeline: decode, multiply, sum, saturate into the output
// register. One request is taken per cycle unless a stalled output has
// backed up into the first stage; each stage has its own ready, so a
// stalled output holds only the stages behind it that are full and bubbles
// close up. Corners return their vertex id, edge points follow num_vertices
// with degree-1 points per edge, interior points follow all edge points.
// Invalid indexes return 0 with status 1, results beyond 32 bits saturate
// with status 2. Configuration writes are always taken and must only be
// issued while the pipeline is empty.
`default_nettype none

module bezier_triangle_point_global_index (
	input  wire logic   clk,
	input  wire logic   arst_n,
	btpgi_req_if.sink   item,
	btpgi_rsp_if.source result,
	btpgi_cfg_if.sink   cfg
);

	// Configuration registers
	logic [btpgi_pkg::DEG_W-1:0]    degree_q;
	logic [btpgi_pkg::CORNER_W-1:0] num_vertices_q;
	logic [btpgi_pkg::SIDE_W-1:0]   num_edges_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q       <= btpgi_pkg::DEG_W'(1);
			num_vertices_q <= '0;
			num_edges_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				btpgi_pkg::REG_DEGREE:       degree_q       <= cfg.data[btpgi_pkg::DEG_W-1:0];
				btpgi_pkg::REG_NUM_VERTICES: num_vertices_q <= cfg.data[btpgi_pkg::CORNER_W-1:0];
				btpgi_pkg::REG_NUM_EDGES:    num_edges_q    <= cfg.data[btpgi_pkg::SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// Per-stage advance enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4      = !v_s4 || result.ready;
	assign en_s3      = !v_s3 || en_s4;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign item.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= item.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: validate, classify and pick multiplier operands
	// ------------------------------------------------------------------
	logic [btpgi_pkg::DEG_W-1:0]    d, dm1, dm2, im1, pos, eoff;
	logic [5:0]                     bsum;
	logic                           idx_ok;
	logic                           fwd;
	logic [7:0]                     t1, t2;
	logic [8:0]                     ioff;
	btpgi_pkg::kind_t               kind_d;
	logic                           err_d, corner_d, use_ne_d;
	logic [btpgi_pkg::CORNER_W-1:0] cval_d;
	logic [btpgi_pkg::SIDE_W-1:0]   mula_d;
	logic [6:0]                     mulb_d;
	logic [7:0]                     off_d;

	always_comb begin
		d      = degree_q;
		dm1    = d - 4'd1;
		dm2    = d - 4'd2;
		bsum   = 6'(item.bez_i) + 6'(item.bez_j) + 6'(item.bez_k);
		idx_ok = (d != '0) && (32'(d) <= btpgi_pkg::MAX_DEGREE) && (bsum == 6'(d));

		// interior offset, lexicographic in (i, j)
		im1  = item.bez_i - 4'd1;
		t1   = 8'(im1) * 8'(dm1);
		t2   = 8'(8'(im1) * 8'(item.bez_i)) >> 1;
		ioff = 9'(t1) - 9'(t2) + 9'(item.bez_j) - 9'd1;

		// edge position counted from the edge start
		if (item.bez_i == '0) begin
			pos = item.bez_k;
			fwd = item.side_forward[0];
		end else if (item.bez_j == '0) begin
			pos = item.bez_i;
			fwd = item.side_forward[1];
		end else begin
			pos = item.bez_j;
			fwd = item.side_forward[2];
		end
		eoff = fwd ? (pos - 4'd1) : (dm2 - (pos - 4'd1));

		kind_d   = btpgi_pkg::KIND_VERTEX;
		err_d    = 1'b0;
		corner_d = 1'b0;
		use_ne_d = 1'b0;
		cval_d   = '0;
		mula_d   = '0;
		mulb_d   = '0;
		off_d    = '0;

		if (!idx_ok) begin
			err_d = 1'b1;
		end else if (item.bez_i == d) begin
			corner_d = 1'b1;
			cval_d   = item.corner_a;
		end else if (item.bez_j == d) begin
			corner_d = 1'b1;
			cval_d   = item.corner_b;
		end else if (item.bez_k == d) begin
			corner_d = 1'b1;
			cval_d   = item.corner_c;
		end else if (item.bez_i == '0 || item.bez_j == '0 || item.bez_k == '0) begin
			kind_d = btpgi_pkg::KIND_EDGE;
			mula_d = (item.bez_i == '0) ? item.side_a :
			         (item.bez_j == '0) ? item.side_b : item.side_c;
			mulb_d = 7'(dm1);
			off_d  = 8'(eoff);
		end else begin
			kind_d   = btpgi_pkg::KIND_INTERIOR;
			use_ne_d = 1'b1;
			mula_d   = btpgi_pkg::SIDE_W'(item.tri_number);
			mulb_d   = btpgi_pkg::tri_points(d);
			off_d    = ioff[7:0];
		end
	end

	btpgi_pkg::kind_t               kind_s1;
	logic                           err_s1, corner_s1, use_ne_s1;
	logic [btpgi_pkg::CORNER_W-1:0] cval_s1;
	logic [btpgi_pkg::SIDE_W-1:0]   mula_s1;
	logic [6:0]                     mulb_s1;
	logic [7:0]                     off_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && item.valid) begin
			kind_s1   <= kind_d;
			err_s1    <= err_d;
			corner_s1 <= corner_d;
			use_ne_s1 <= use_ne_d;
			cval_s1   <= cval_d;
			mula_s1   <= mula_d;
			mulb_s1   <= mulb_d;
			off_s1    <= off_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: products and base address
	// ------------------------------------------------------------------
	btpgi_pkg::kind_t             kind_s2;
	logic                         err_s2;
	logic [btpgi_pkg::SIDE_W-1:0] base_s2;
	logic [31:0]                  prod1_s2;
	logic [28:0]                  prod2_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			kind_s2  <= kind_s1;
			err_s2   <= err_s1;
			prod1_s2 <= 32'(mula_s1) * 32'(mulb_s1);
			prod2_s2 <= use_ne_s1 ? 29'(29'(num_edges_q) * 29'(degree_q - 4'd1)) : '0;
			if (err_s1)
				base_s2 <= '0;
			else if (corner_s1)
				base_s2 <= btpgi_pkg::SIDE_W'(cval_s1);
			else
				base_s2 <= btpgi_pkg::SIDE_W'(num_vertices_q) + btpgi_pkg::SIDE_W'(off_s1);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: full-width sum
	// ------------------------------------------------------------------
	btpgi_pkg::kind_t kind_s3;
	logic             err_s3;
	logic [33:0]      total_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			kind_s3  <= kind_s2;
			err_s3   <= err_s2;
			total_s3 <= 34'(base_s2) + 34'(prod1_s2) + 34'(prod2_s2);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: saturate into the output register
	// ------------------------------------------------------------------
	logic                          ovf;
	logic [btpgi_pkg::POINT_W-1:0] point_s4;
	btpgi_pkg::kind_t              kind_s4;
	btpgi_pkg::status_t            status_s4;

	assign ovf = (total_s3[33:32] != 2'b00);

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			kind_s4  <= kind_s3;
			point_s4 <= ovf ? '1 : total_s3[31:0];
			if (err_s3)
				status_s4 <= btpgi_pkg::ST_INVALID;
			else if (ovf)
				status_s4 <= btpgi_pkg::ST_OVERFLOW;
			else
				status_s4 <= btpgi_pkg::ST_OK;
		end
	end

	assign result.valid        = v_s4;
	assign result.global_point = point_s4;
	assign result.point_kind   = kind_s4;
	assign result.status       = status_s4;

endmodule

`default_nettype wire

// ----- rtl/btpgi_checker.sv -----
// ----------------------------------------------------------------------------
// btpgi_checker
// Port-level checks on the result channel of the point index block.
// ----------------------------------------------------------------------------
`default_nettype none

module btpgi_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic [btpgi_pkg::POINT_W-1:0]      global_point,
	input wire logic [btpgi_pkg::KIND_W-1:0]       point_kind,
	input wire logic [btpgi_pkg::STATUS_W-1:0]     status
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(global_point)
			&& $stable(point_kind) && $stable(status))
		else $error("stalled result changed");

	// Invalid index reads as vertex zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == btpgi_pkg::ST_INVALID |->
			global_point == '0 && point_kind == btpgi_pkg::KIND_VERTEX)
		else $error("invalid request returned nonzero point");

	// Overflow saturates
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == btpgi_pkg::ST_OVERFLOW |-> global_point == '1
			&& point_kind != btpgi_pkg::KIND_VERTEX)
		else $error("overflow not saturated");

	// Corners are passed through and cannot overflow
	a_vertex_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_kind == btpgi_pkg::KIND_VERTEX |->
			status == btpgi_pkg::ST_OK || status == btpgi_pkg::ST_INVALID)
		else $error("vertex result with overflow status");

endmodule

bind bezier_triangle_point_global_index btpgi_checker u_btpgi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.global_point (result.global_point),
	.point_kind   (result.point_kind),
	.status       (result.status)
);

`default_nettype wire

// ----- bench/tb_bezier_triangle_point_global_index.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bezier_triangle_point_global_index
// Self-checking bench for the Bezier triangle control point index block.
// Requests go in over the item channel while the result channel is checked
// against a predictor kept in the bench. Directed checks cover the reset
// degree, field extremes, both edge directions, interior points and
// degree zero. Random mixes then run under several register settings and
// idle/stall patterns. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------

module tb_bezier_triangle_point_global_index;

	localparam int unsigned PIPE_LATENCY = 4;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam logic [btpgi_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [btpgi_pkg::CORNER_W-1:0] corner_a;
		logic [btpgi_pkg::CORNER_W-1:0] corner_b;
		logic [btpgi_pkg::CORNER_W-1:0] corner_c;
		logic [btpgi_pkg::SIDE_W-1:0]   side_a;
		logic [btpgi_pkg::SIDE_W-1:0]   side_b;
		logic [btpgi_pkg::SIDE_W-1:0]   side_c;
		logic [2:0]                     side_forward;
		logic [btpgi_pkg::TRI_W-1:0]    tri_number;
		logic [btpgi_pkg::BEZ_W-1:0]    bez_i;
		logic [btpgi_pkg::BEZ_W-1:0]    bez_j;
		logic [btpgi_pkg::BEZ_W-1:0]    bez_k;
	} point_req_t;

	typedef struct packed {
		logic [btpgi_pkg::POINT_W-1:0] global_point;
		btpgi_pkg::kind_t              point_kind;
		btpgi_pkg::status_t            status;
	} point_res_t;

	logic clk;
	logic arst_n;

	btpgi_req_if item_ch ();
	btpgi_rsp_if result_ch ();
	btpgi_cfg_if cfg_ch ();

	bezier_triangle_point_global_index u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Bench copy of the configuration registers
	logic [btpgi_pkg::DEG_W-1:0]    cfg_degree;
	logic [btpgi_pkg::CORNER_W-1:0] cfg_num_vertices;
	logic [btpgi_pkg::SIDE_W-1:0]   cfg_num_edges;

	point_res_t  expected_points[$];
	int unsigned error_count;
	int unsigned send_idle_pct;
	int unsigned stall_pct;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp a wide sum to 32 bits and flag the overflow
	function automatic point_res_t saturate_point(input logic [63:0] total,
	                                              input btpgi_pkg::kind_t kind);
		point_res_t res;
		res.point_kind = kind;
		if (total > 64'hFFFF_FFFF) begin
			res.global_point = '1;
			res.status       = btpgi_pkg::ST_OVERFLOW;
		end else begin
			res.global_point = total[btpgi_pkg::POINT_W-1:0];
			res.status       = btpgi_pkg::ST_OK;
		end
		return res;
	endfunction

	// Global control point number for one request under the current registers
	function automatic point_res_t compute_global_point(input point_req_t r);
		logic [63:0] corner[3];
		logic [63:0] side[3];
		logic [63:0] bz[3];
		logic [63:0] d, offset, total;
		point_res_t  res;
		int          n;
		corner[0] = 64'(r.corner_a);
		corner[1] = 64'(r.corner_b);
		corner[2] = 64'(r.corner_c);
		side[0]   = 64'(r.side_a);
		side[1]   = 64'(r.side_b);
		side[2]   = 64'(r.side_c);
		bz[0]     = 64'(r.bez_i);
		bz[1]     = 64'(r.bez_j);
		bz[2]     = 64'(r.bez_k);
		d         = 64'(cfg_degree);
		res.global_point = '0;
		res.point_kind   = btpgi_pkg::KIND_VERTEX;
		res.status       = btpgi_pkg::ST_INVALID;
		if (d == 0 || d > btpgi_pkg::MAX_DEGREE || bz[0] + bz[1] + bz[2] != d)
			return res;
		// corner: one component carries the whole degree
		for (n = 0; n < 3; n++) begin
			if (bz[n] == d) begin
				res.global_point = corner[n][btpgi_pkg::POINT_W-1:0];
				res.status       = btpgi_pkg::ST_OK;
				return res;
			end
		end
		// edge point: the zero component names the edge
		for (n = 0; n < 3; n++) begin
			if (bz[n] == 0) begin
				offset = bz[(n + 2) % 3] - 1;
				if (!r.side_forward[n])
					offset = d - 2 - offset;
				total = 64'(cfg_num_vertices) + side[n] * (d - 1) + offset;
				return saturate_point(total, btpgi_pkg::KIND_EDGE);
			end
		end
		// interior point: lexicographic in (i, j) after all edge points
		offset = (bz[0] - 1) * (d - 1) - ((bz[0] - 1) * bz[0]) / 2 + (bz[1] - 1);
		total  = 64'(cfg_num_vertices) + 64'(cfg_num_edges) * (d - 1)
		       + 64'(r.tri_number) * (((d - 1) * (d - 2)) / 2) + offset;
		return saturate_point(total, btpgi_pkg::KIND_INTERIOR);
	endfunction

	// Request with the given Bezier index and random triangle topology
	function automatic point_req_t make_request(input int unsigned bi, input int unsigned bj,
	                                            input int unsigned bk);
		point_req_t r;
		r.corner_a     = btpgi_pkg::CORNER_W'($urandom());
		r.corner_b     = btpgi_pkg::CORNER_W'($urandom());
		r.corner_c     = btpgi_pkg::CORNER_W'($urandom());
		r.side_a       = btpgi_pkg::SIDE_W'($urandom());
		r.side_b       = btpgi_pkg::SIDE_W'($urandom());
		r.side_c       = btpgi_pkg::SIDE_W'($urandom());
		r.side_forward = 3'($urandom());
		r.tri_number   = btpgi_pkg::TRI_W'($urandom());
		r.bez_i        = btpgi_pkg::BEZ_W'(bi);
		r.bez_j        = btpgi_pkg::BEZ_W'(bj);
		r.bez_k        = btpgi_pkg::BEZ_W'(bk);
		return r;
	endfunction

	// Drive one request, hold it until taken, then queue its prediction
	task automatic send_request(input point_req_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.corner_a     = r.corner_a;
		item_ch.corner_b     = r.corner_b;
		item_ch.corner_c     = r.corner_c;
		item_ch.side_a       = r.side_a;
		item_ch.side_b       = r.side_b;
		item_ch.side_c       = r.side_c;
		item_ch.side_forward = r.side_forward;
		item_ch.tri_number   = r.tri_number;
		item_ch.bez_i        = r.bez_i;
		item_ch.bez_j        = r.bez_j;
		item_ch.bez_k        = r.bez_k;
		item_ch.valid        = 1'b1;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		expected_points.insert(expected_points.size(), compute_global_point(r));
	endtask

	// Drop the request valid and let the pipeline empty out
	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Write one configuration register and mirror it in the predictor
	task automatic write_register(input logic [btpgi_pkg::CFG_IDX_W-1:0] idx,
	                              input logic [btpgi_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.index = idx;
		cfg_ch.data  = value;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			btpgi_pkg::REG_DEGREE:       cfg_degree       = value[btpgi_pkg::DEG_W-1:0];
			btpgi_pkg::REG_NUM_VERTICES: cfg_num_vertices = value[btpgi_pkg::CORNER_W-1:0];
			btpgi_pkg::REG_NUM_EDGES:    cfg_num_edges    = value[btpgi_pkg::SIDE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Reset registers: degree one, so only corners are valid
	task automatic test_reset_state();
		send_request(make_request(1, 0, 0));
		send_request(make_request(0, 1, 0));
		send_request(make_request(0, 0, 1));
		send_request(make_request(0, 0, 0));
		send_request(make_request(1, 1, 0));
		wait_drained();
	endtask

	// Top degree and full-scale ids, both directions on every edge
	task automatic test_extremes();
		point_req_t  r;
		int unsigned bz[3];
		int unsigned n, z;
		write_register(btpgi_pkg::REG_DEGREE, {21'h1F_FFFF, 4'd15});
		write_register(btpgi_pkg::REG_NUM_VERTICES, '1);
		write_register(btpgi_pkg::REG_NUM_EDGES, '1);
		r = make_request(15, 0, 0);
		r.corner_a = '1;
		send_request(r);
		for (n = 0; n < 6; n++) begin
			z = n / 2;
			bz[z] = 0;
			bz[(z + 1) % 3] = 14;
			bz[(z + 2) % 3] = 1;
			r = make_request(bz[0], bz[1], bz[2]);
			r.side_a = '1;
			r.side_b = '1;
			r.side_c = '1;
			r.side_forward = (n % 2 != 0) ? 3'b111 : 3'b000;
			send_request(r);
		end
		r = make_request(1, 1, 13);
		r.tri_number = '1;
		send_request(r);
		r = make_request(13, 1, 1);
		r.tri_number = '1;
		send_request(r);
		r = make_request(1, 13, 1);
		r.tri_number = '1;
		send_request(r);
		send_request(make_request(15, 15, 15));
		wait_drained();
	endtask

	// A write to the spare index must leave every register alone
	task automatic test_unused_register();
		write_register(REG_SPARE, '1);
		send_request(make_request(0, 0, 15));
		send_request(make_request(0, 7, 8));
		wait_drained();
	endtask

	// Degrees two and three, then degree zero where nothing is valid
	task automatic test_small_degrees();
		point_req_t r;
		write_register(btpgi_pkg::REG_NUM_VERTICES, 25'd5);
		write_register(btpgi_pkg::REG_DEGREE, 25'd2);
		r = make_request(1, 1, 0);
		r.side_forward = 3'b000;
		send_request(r);
		r.side_forward = 3'b111;
		send_request(r);
		wait_drained();
		write_register(btpgi_pkg::REG_DEGREE, 25'd3);
		send_request(make_request(1, 1, 1));
		wait_drained();
		write_register(btpgi_pkg::REG_DEGREE, {21'h1F_FFFF, 4'd0});
		send_request(make_request(0, 0, 0));
		send_request(make_request(1, 0, 0));
		wait_drained();
	endtask

	// Random mixes of corners, edge and interior points over several settings
	task automatic test_random_mix(input int unsigned items_per_setting);
		point_req_t  r;
		int unsigned d, roll, z, a, s, k;
		int unsigned bz[3];
		for (s = 0; s < 8; s++) begin
			wait_drained();
			case (s)
				0:       d = 15;
				1:       d = 2;
				2:       d = 3;
				3:       d = 1;
				6:       d = $urandom_range(0, 15);
				default: d = $urandom_range(1, 15);
			endcase
			write_register(btpgi_pkg::REG_DEGREE, {21'($urandom()), 4'(d)});
			write_register(btpgi_pkg::REG_NUM_VERTICES,
				(s == 0) ? '1 : (s == 3) ? '0 : btpgi_pkg::CFG_DATA_W'($urandom()));
			write_register(btpgi_pkg::REG_NUM_EDGES,
				(s == 0) ? '1 : (s == 3) ? '0 : btpgi_pkg::CFG_DATA_W'($urandom()));
			// idle pattern for this phase
			case (s % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 81; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 81; end
				default: begin send_idle_pct = 18; stall_pct = 18; end
			endcase
			for (k = 0; k < items_per_setting; k++) begin
				roll  = $urandom_range(0, 99);
				z     = $urandom_range(0, 2);
				bz[0] = 0;
				bz[1] = 0;
				bz[2] = 0;
				if (roll < 10 || d == 0) begin
					bz[0] = $urandom_range(0, 15);
					bz[1] = $urandom_range(0, 15);
					bz[2] = $urandom_range(0, 15);
				end else if (roll < 30 || d < 2) begin
					bz[z] = d;
				end else if (roll < 65 || d < 3) begin
					a = $urandom_range(1, d - 1);
					bz[(z + 1) % 3] = a;
					bz[(z + 2) % 3] = d - a;
				end else begin
					bz[0] = $urandom_range(1, d - 2);
					bz[1] = $urandom_range(1, d - 1 - bz[0]);
					bz[2] = d - bz[0] - bz[1];
				end
				r = make_request(bz[0], bz[1], bz[2]);
				send_request(r);
			end
		end
		wait_drained();
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	// Result ready, redrawn every cycle
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Compare each taken result with the oldest prediction
	always @(posedge clk) begin : result_check
		point_res_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_points.size() == 0) begin
				$display("%0t: result with no request pending: global_point %h kind %0d status %0d",
				         $time, result_ch.global_point, result_ch.point_kind, result_ch.status);
				error_count++;
			end else begin
				want = expected_points.pop_front();
				if (result_ch.global_point !== want.global_point) begin
					$display("%0t: global_point expected %h actual %h",
					         $time, want.global_point, result_ch.global_point);
					error_count++;
				end
				if (result_ch.point_kind !== want.point_kind) begin
					$display("%0t: point_kind expected %0d actual %0d",
					         $time, want.point_kind, result_ch.point_kind);
					error_count++;
				end
				if (result_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
					         $time, want.status, result_ch.status);
					error_count++;
				end
			end
		end
	end

	// End the run when no channel handshakes for too long
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n
			    || (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
			    || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
			    || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("bezier_triangle_point_global_index verification failed");
		$finish;
	end

	// Test sequence
	initial begin
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.corner_a     = '0;
		item_ch.corner_b     = '0;
		item_ch.corner_c     = '0;
		item_ch.side_a       = '0;
		item_ch.side_b       = '0;
		item_ch.side_c       = '0;
		item_ch.side_forward = '0;
		item_ch.tri_number   = '0;
		item_ch.bez_i        = '0;
		item_ch.bez_j        = '0;
		item_ch.bez_k        = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = btpgi_pkg::REG_DEGREE;
		cfg_ch.data          = '0;
		cfg_degree           = 4'd1;
		cfg_num_vertices     = '0;
		cfg_num_edges        = '0;
		error_count          = 0;
		send_idle_pct        = 0;
		stall_pct            = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_extremes();
		test_unused_register();
		test_small_degrees();
		test_random_mix(150);

		if (error_count == 0)
			$display("bezier_triangle_point_global_index verification clean");
		else
			$display("bezier_triangle_point_global_index verification failed");
		$finish;
	end

endmodule

// ----- bezier_triangle_point_global_index.f -----
rtl/btpgi_pkg.sv
rtl/btpgi_ifs.sv
rtl/bezier_triangle_point_global_index.sv
rtl/btpgi_checker.sv
bench/tb_bezier_triangle_point_global_index.sv
